[hw/rtl/bitc_pkg.sv]
// Shared types, codes and defaults for the BMP icon to tile converter.
package bitc_pkg;

  localparam int ICON_SIDE_DEF     = 32;
  localparam int PALETTE_COUNT_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Coordinates are carried at the width of the largest supported icon side.
  localparam int COORD_W = 8;

  localparam logic [1:0] KIND_PALETTE = 2'd0;
  localparam logic [1:0] KIND_TILE    = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SIG    = 3'd1;
  localparam logic [2:0] ST_UNSUPPORT  = 3'd2;
  localparam logic [2:0] ST_OFS_IN_HDR = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;

  localparam logic [1:0] CMD_COLOR  = 2'd0;
  localparam logic [1:0] CMD_TILE   = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  typedef struct packed {
    logic       first_byte;
    logic [7:0] byte_value;
    logic       final_byte;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  index;
    logic [14:0] value;
    logic [2:0]  status;
    logic        done_res;
  } res_item_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         entry;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [14:0]        data;
    logic [2:0]         status;
    logic               done;
  } cmd_t;

endpackage

[hw/rtl/bitc_fifo.sv]
// Small register queue between the byte parser and the result formatter.
module bitc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[hw/rtl/bitc_front.sv]
// Byte parser: tracks file position, checks the header and classifies each byte.
module bitc_front #(
  parameter int ICON_SIDE     = bitc_pkg::ICON_SIDE_DEF,
  parameter int PALETTE_COUNT = bitc_pkg::PALETTE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  bitc_pkg::byte_item_t byte_item,
  output logic                push,
  output bitc_pkg::cmd_t      cmd
);
  import bitc_pkg::*;

  localparam int XW = $clog2(ICON_SIDE);
  localparam logic [XW-1:0] SIDE_M1  = XW'(ICON_SIDE - 1);
  localparam logic [31:0]   SIDE_W   = 32'(ICON_SIDE);
  localparam logic [31:0]   HDR_END  = 32'(54 + 4 * PALETTE_COUNT);
  localparam logic [31:0]   POS_SIG  = 32'h1;
  localparam logic [31:0]   POS_OFS  = 32'hD;
  localparam logic [31:0]   POS_WID  = 32'h15;
  localparam logic [31:0]   POS_HGT  = 32'h19;
  localparam logic [31:0]   POS_BPP  = 32'h1D;
  localparam logic [31:0]   PAL_BASE = 32'h36;
  localparam logic [31:0]   PIX_MIN  = 32'h1E;
  localparam logic [31:0]   POS_MAX  = 32'hFFFF_FFFF;
  localparam logic [7:0]    SIG_B    = 8'h42;
  localparam logic [7:0]    SIG_M    = 8'h4D;
  localparam logic [15:0]   BPP_8    = 16'd8;

  logic [31:0]   pos;
  logic [31:0]   data_ofs;
  logic [31:0]   hdr_word;
  logic          top_down;
  logic [9:0]    partial;
  logic [3:0]    held;
  logic          finished;
  logic          format_ok;
  logic          pix_run;
  logic [XW-1:0] xcnt;
  logic [XW-1:0] ycnt;

  logic [31:0]   pos_c, ofs_c, hw_c;
  logic          top_c, fin_c, fmt_c, run_c;
  logic [9:0]    partial_c;
  logic [3:0]    held_c;
  logic [XW-1:0] x_c, y_c;

  logic [31:0]   pos_next, data_ofs_next, hdr_word_next, mag;
  logic          top_down_next, finished_next, format_ok_next, pix_run_next;
  logic [9:0]    partial_next;
  logic [3:0]    held_next;
  logic [XW-1:0] xcnt_next, ycnt_next, ydst;
  logic [5:0]    rel;
  logic          pal_hit, pix_now, has_res, done;
  logic [7:0]    b;
  cmd_t          res;

  always_comb begin
    b = byte_item.byte_value;

    // A first byte restarts the parse from the reset state before decoding.
    pos_c     = byte_item.first_byte ? '0 : pos;
    ofs_c     = byte_item.first_byte ? '0 : data_ofs;
    hw_c      = byte_item.first_byte ? '0 : hdr_word;
    top_c     = byte_item.first_byte ? 1'b0 : top_down;
    partial_c = byte_item.first_byte ? '0 : partial;
    held_c    = byte_item.first_byte ? '0 : held;
    fin_c     = byte_item.first_byte ? 1'b0 : finished;
    fmt_c     = byte_item.first_byte ? 1'b0 : format_ok;
    run_c     = byte_item.first_byte ? 1'b0 : pix_run;
    x_c       = byte_item.first_byte ? '0 : xcnt;
    y_c       = byte_item.first_byte ? '0 : ycnt;

    hdr_word_next = {b, hw_c[31:8]};
    data_ofs_next = ofs_c;
    top_down_next = top_c;
    format_ok_next = fmt_c;
    partial_next  = partial_c;
    held_next     = held_c;
    xcnt_next     = x_c;
    ycnt_next     = y_c;
    mag           = hdr_word_next;
    rel           = pos_c[5:0] - PAL_BASE[5:0];
    pal_hit       = (pos_c >= PAL_BASE) && (pos_c < HDR_END);
    ydst          = top_c ? y_c : (SIDE_M1 - y_c);
    has_res       = 1'b0;
    done          = 1'b0;

    res        = '0;
    res.op     = CMD_STATUS;
    res.status = ST_OK;

    if (pos_c == POS_SIG) begin
      if (hdr_word_next[23:16] != SIG_B || b != SIG_M) begin
        has_res    = 1'b1;
        done       = 1'b1;
        res.status = ST_BAD_SIG;
      end
    end else if (pos_c == POS_OFS) begin
      data_ofs_next = hdr_word_next;
    end else if (pos_c == POS_WID) begin
      format_ok_next = (hdr_word_next == SIDE_W);
    end else if (pos_c == POS_HGT) begin
      top_down_next = hdr_word_next[31];
      if (hdr_word_next[31]) begin
        mag = 32'd0 - hdr_word_next;
      end
      if (mag != SIDE_W) begin
        format_ok_next = 1'b0;
      end
    end else if (pos_c == POS_BPP) begin
      if (!fmt_c || hdr_word_next[31:16] != BPP_8) begin
        has_res    = 1'b1;
        done       = 1'b1;
        res.status = ST_UNSUPPORT;
      end else if (ofs_c < HDR_END) begin
        has_res    = 1'b1;
        done       = 1'b1;
        res.status = ST_OFS_IN_HDR;
      end
    end else if (pal_hit) begin
      case (rel[1:0])
        2'd0: partial_next = {b[7:3], 5'd0};
        2'd1: partial_next = {partial_c[9:5], b[7:3]};
        2'd2: begin
          has_res   = 1'b1;
          res.op    = CMD_COLOR;
          res.entry = rel[5:2];
          res.data  = {partial_c, b[7:3]};
        end
        default: ;
      endcase
    end

    // Pixel data runs from the data offset on; the offset is past the palette
    // once the header checks pass, so no header result competes with it.
    pix_now = run_c || ((pos_c == ofs_c) && (pos_c >= PIX_MIN));
    pix_run_next = pix_now;
    if (pix_now && !has_res) begin
      if (!x_c[0]) begin
        held_next = b[3:0];
      end else begin
        has_res  = 1'b1;
        res.op   = CMD_TILE;
        res.x    = COORD_W'(x_c);
        res.y    = COORD_W'(ydst);
        res.data = {7'd0, b[3:0], held_c};
        if (x_c == SIDE_M1 && y_c == SIDE_M1) begin
          done = 1'b1;
        end
      end
      // The pixel counters follow the position, which stops at its maximum.
      if (pos_c != POS_MAX) begin
        if (x_c == SIDE_M1) begin
          xcnt_next = '0;
          ycnt_next = y_c + XW'(1);
        end else begin
          xcnt_next = x_c + XW'(1);
        end
      end
    end

    if (!done && byte_item.final_byte) begin
      has_res    = 1'b1;
      done       = 1'b1;
      res        = '0;
      res.op     = CMD_STATUS;
      res.status = ST_TRUNCATED;
    end

    res.done      = done;
    pos_next      = (pos_c == POS_MAX) ? pos_c : pos_c + 32'd1;
    finished_next = done ? 1'b1 : fin_c;
  end

  assign push = take && !fin_c && has_res;
  assign cmd  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      data_ofs  <= '0;
      hdr_word  <= '0;
      top_down  <= 1'b0;
      partial   <= '0;
      held      <= '0;
      finished  <= 1'b1;
      format_ok <= 1'b0;
      pix_run   <= 1'b0;
      xcnt      <= '0;
      ycnt      <= '0;
    end else if (take && !fin_c) begin
      pos       <= pos_next;
      data_ofs  <= data_ofs_next;
      hdr_word  <= hdr_word_next;
      top_down  <= top_down_next;
      partial   <= partial_next;
      held      <= held_next;
      finished  <= finished_next;
      format_ok <= format_ok_next;
      pix_run   <= pix_run_next;
      xcnt      <= xcnt_next;
      ycnt      <= ycnt_next;
    end
  end

endmodule

[hw/rtl/bitc_back.sv]
// Result formatter: turns queued commands into result items in an output register.
module bitc_back #(
  parameter int ICON_SIDE = bitc_pkg::ICON_SIDE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  bitc_pkg::cmd_t      head,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_ready,
  output bitc_pkg::res_item_t res_item
);
  import bitc_pkg::*;

  localparam int TILES_ROW = ICON_SIDE >> 3;

  // Only the low tile bits reach the 9-bit index.
  logic [3:0]  tile;
  res_item_t   fmt;

  always_comb begin
    tile = 4'(16'(head.y[COORD_W-1:3]) * 16'(TILES_ROW) + 16'(head.x[COORD_W-1:3]));
    fmt  = '0;
    unique case (head.op)
      CMD_COLOR: begin
        fmt.kind  = KIND_PALETTE;
        fmt.index = 9'(head.entry);
        fmt.value = head.data;
      end
      CMD_TILE: begin
        // 32 bytes per tile, 4 bytes per tile row, two pixels per byte.
        fmt.kind  = KIND_TILE;
        fmt.index = {tile, head.y[2:0], head.x[2:1]};
        fmt.value = head.data;
      end
      CMD_STATUS: begin
        fmt.kind = KIND_STATUS;
      end
      default: begin
        fmt.kind = KIND_STATUS;
      end
    endcase
    fmt.status   = head.status;
    fmt.done_res = head.done;
  end

  assign pop = head_valid && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_item <= fmt;
    end
  end

endmodule

[hw/rtl/bmp_icon_to_tile_converter.sv]
// Top level of the BMP icon to 4 bpp tile converter: parser, queue and formatter.
// A result passes from the parser through the queue into the output register and transfers when res_ready is high.
// Throughput: one byte per cycle unless the queue is full, set by the combinational position decode in the parser.
// Bytes that cause no result still pass through the parser; input stalls only while the queue is full.
// Reset (rst, synchronous): queue and output empty, parser idle until a first byte.
module bmp_icon_to_tile_converter #(
  parameter int ICON_SIDE     = bitc_pkg::ICON_SIDE_DEF,
  parameter int PALETTE_COUNT = bitc_pkg::PALETTE_COUNT_DEF,
  parameter int QUEUE_DEPTH   = bitc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  bitc_pkg::byte_item_t byte_item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output bitc_pkg::res_item_t  res_item
);
  import bitc_pkg::*;

  logic q_push, q_pop, q_full, q_empty, take;
  cmd_t q_wdata, q_rdata;

  assign byte_ready = !q_full;
  assign take       = byte_valid && byte_ready;

  bitc_front #(
    .ICON_SIDE    (ICON_SIDE),
    .PALETTE_COUNT(PALETTE_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .byte_item(byte_item),
    .push     (q_push),
    .cmd      (q_wdata)
  );

  bitc_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  bitc_back #(
    .ICON_SIDE(ICON_SIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(!q_empty),
    .head      (q_rdata),
    .pop       (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue written while full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command queue read while empty");

  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_item.done_res) |-> (res_item.status == ST_OK))
    else $error("error status on a result that does not end the file");

  a_status_kind_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.kind == KIND_STATUS) |-> res_item.done_res)
    else $error("status-only result without the done flag");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the BMP icon to 4 bpp tile converter.
`timescale 1ns / 100ps

module tb_top;
  import bitc_pkg::*;

  localparam int          ICON         = ICON_SIDE_DEF;
  localparam int          PIXELS       = ICON * ICON;
  localparam logic [31:0] PALETTE_BASE = 32'h36;
  localparam logic [31:0] HDR_END      = PALETTE_BASE + 4 * PALETTE_COUNT_DEF;
  localparam logic [7:0]  SIG_B        = 8'h42;
  localparam logic [7:0]  SIG_M        = 8'h4D;
  localparam int          TOTAL_ITEMS  = 1050;
  localparam int          RANDOM_ITEMS = 100;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          STUCK_LIMIT  = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  byte_item_t byte_item = '0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  res_item_t  res_item;

  bmp_icon_to_tile_converter u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item (byte_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  // Parser state as the predictor sees it.
  logic [31:0] pos_q;
  logic [31:0] data_ofs_q;
  logic [31:0] hdr_word_q;
  logic        top_down_q;
  logic [9:0]  part_color_q;
  logic [3:0]  held_nib_q;
  logic        done_q = 1'b1;
  logic        fmt_ok_q;

  res_item_t converted_q[$];
  res_item_t want_res;
  int        mismatches = 0;
  int        sent_bytes = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;
  int        stuck_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the result, if any, that one accepted byte causes.
  task automatic convert_byte(input byte_item_t it, output bit has_res, output res_item_t r);
    logic [31:0] pos, mag, p, x, sy, y, tile, rel;
    logic [7:0]  b;
    bit          produce, done;
    logic [1:0]  kind;
    logic [8:0]  idx;
    logic [14:0] val;
    logic [2:0]  st;
    has_res = 1'b0;
    r = '0;
    if (it.first_byte) begin
      pos_q = '0;
      data_ofs_q = '0;
      hdr_word_q = '0;
      top_down_q = 1'b0;
      part_color_q = '0;
      held_nib_q = '0;
      done_q = 1'b0;
      fmt_ok_q = 1'b0;
    end
    if (done_q) return;
    b = it.byte_value;
    pos = pos_q;
    hdr_word_q = {b, hdr_word_q[31:8]};
    produce = 1'b0;
    done = 1'b0;
    kind = KIND_STATUS;
    idx = '0;
    val = '0;
    st = ST_OK;
    if (pos == 32'h1) begin
      if (hdr_word_q[23:16] != SIG_B || b != SIG_M) begin
        produce = 1'b1; st = ST_BAD_SIG; done = 1'b1;
      end
    end else if (pos == 32'hD) begin
      data_ofs_q = hdr_word_q;
    end else if (pos == 32'h15) begin
      fmt_ok_q = (hdr_word_q == 32'(ICON));
    end else if (pos == 32'h19) begin
      top_down_q = hdr_word_q[31];
      mag = top_down_q ? (32'd0 - hdr_word_q) : hdr_word_q;
      if (mag != 32'(ICON)) fmt_ok_q = 1'b0;
    end else if (pos == 32'h1D) begin
      if (!fmt_ok_q || hdr_word_q[31:16] != 16'd8) begin
        produce = 1'b1; st = ST_UNSUPPORT; done = 1'b1;
      end else if (data_ofs_q < HDR_END) begin
        produce = 1'b1; st = ST_OFS_IN_HDR; done = 1'b1;
      end
    end else if (pos >= PALETTE_BASE && pos < HDR_END) begin
      rel = pos - PALETTE_BASE;
      case (rel[1:0])
        2'd0: part_color_q = {b[7:3], 5'd0};
        2'd1: part_color_q = {part_color_q[9:5], b[7:3]};
        2'd2: begin
          produce = 1'b1;
          kind = KIND_PALETTE;
          idx = 9'(rel >> 2);
          val = {part_color_q, b[7:3]};
        end
        default: ;
      endcase
    end
    if (!produce && pos >= 32'h1E && pos >= data_ofs_q) begin
      p = pos - data_ofs_q;
      if (p < 32'(PIXELS)) begin
        x = p % ICON;
        sy = p / ICON;
        if (!x[0]) begin
          held_nib_q = b[3:0];
        end else begin
          y = top_down_q ? sy : (32'(ICON) - 1 - sy);
          tile = (y >> 3) * (ICON >> 3) + (x >> 3);
          produce = 1'b1;
          kind = KIND_TILE;
          idx = 9'(tile * 32 + (y & 7) * 4 + ((x & 7) >> 1));
          val = {7'd0, b[3:0], held_nib_q};
          if (p == 32'(PIXELS - 1)) done = 1'b1;
        end
      end
    end
    // A last byte that has not closed the file reports truncation instead.
    if (!done && it.final_byte) begin
      produce = 1'b1; kind = KIND_STATUS; idx = '0; val = '0; st = ST_TRUNCATED; done = 1'b1;
    end
    if (pos_q != 32'hFFFF_FFFF) pos_q = pos_q + 1;
    if (done) done_q = 1'b1;
    has_res = produce;
    r.kind = kind;
    r.index = idx;
    r.value = val;
    r.status = st;
    r.done_res = done;
  endtask

  function automatic byte_item_t mk_byte(bit first, logic [7:0] v, bit last);
    byte_item_t it;
    it.first_byte = first;
    it.byte_value = v;
    it.final_byte = last;
    return it;
  endfunction

  // Entered just after a rising edge; returns at the edge of the transfer.
  // The idling phase follows the number of bytes sent so far in the run.
  task automatic send_byte(input byte_item_t it);
    bit        has_res;
    res_item_t r;
    case (sent_bytes * 4 / TOTAL_ITEMS)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    convert_byte(it, has_res, r);
    if (has_res) converted_q.push_back(r);
    sent_bytes++;
  endtask

  task automatic send_bmp(input int len, input bit mark_final, input logic [7:0] sig0,
                          input logic [7:0] sig1, input logic [31:0] width,
                          input logic [31:0] height, input logic [15:0] bpp,
                          input logic [31:0] data_ofs);
    logic [7:0] hdr [0:'h35];
    int         i;
    for (i = 0; i < 'h36; i++) hdr[i] = 8'($urandom);
    hdr[0] = sig0;
    hdr[1] = sig1;
    {hdr['h0D], hdr['h0C], hdr['h0B], hdr['h0A]} = data_ofs;
    {hdr['h15], hdr['h14], hdr['h13], hdr['h12]} = width;
    {hdr['h19], hdr['h18], hdr['h17], hdr['h16]} = height;
    {hdr['h1D], hdr['h1C]} = bpp;
    for (i = 0; i < len; i++) begin
      send_byte(mk_byte(i == 0, (i < 'h36) ? hdr[i] : 8'($urandom),
                        mark_final && (i == len - 1)));
    end
  endtask

  task automatic test_idle_bytes();
    send_byte(mk_byte(1'b0, 8'h00, 1'b0));
    send_byte(mk_byte(1'b0, 8'hFF, 1'b1));
    // A file of one byte ends truncated; the byte after it is ignored.
    send_byte(mk_byte(1'b1, SIG_B, 1'b1));
    send_byte(mk_byte(1'b0, SIG_M, 1'b0));
  endtask

  task automatic test_signature();
    send_byte(mk_byte(1'b1, 8'h00, 1'b0));
    send_byte(mk_byte(1'b0, SIG_M, 1'b0));
    send_byte(mk_byte(1'b1, SIG_B, 1'b0));
    send_byte(mk_byte(1'b0, 8'hFF, 1'b0));
    // A bad signature on the last byte reports the signature, not truncation.
    send_byte(mk_byte(1'b1, SIG_B, 1'b0));
    send_byte(mk_byte(1'b0, 8'h00, 1'b1));
    // A first byte in the middle of a file restarts the parse.
    send_byte(mk_byte(1'b1, SIG_B, 1'b0));
    send_byte(mk_byte(1'b1, SIG_B, 1'b0));
    send_byte(mk_byte(1'b0, SIG_M, 1'b0));
    send_byte(mk_byte(1'b0, 8'h55, 1'b1));
    send_byte(mk_byte(1'b1, SIG_B, 1'b0));
    send_byte(mk_byte(1'b0, SIG_M, 1'b1));
  endtask

  // The receiver holds off as a whole icon starts to stream in, so the block fills up.
  task automatic test_full_icon_backpressure();
    byte_valid <= 1'b0;
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    @(posedge clk);
    send_bmp(HDR_END + PIXELS, 1'b1, SIG_B, SIG_M, 32'(ICON),
             $urandom_range(1) ? 32'(ICON) : -32'(ICON), 16'd8, HDR_END);
  endtask

  task automatic test_random_files();
    int          start, len, i;
    bit          fin;
    logic [7:0]  s0, s1;
    logic [31:0] w, h, ofs;
    logic [15:0] bpp;
    start = sent_bytes;
    while (sent_bytes - start < RANDOM_ITEMS) begin
      s0 = SIG_B;
      s1 = SIG_M;
      w = 32'(ICON);
      h = $urandom_range(1) ? 32'(ICON) : -32'(ICON);
      bpp = 16'd8;
      ofs = ($urandom_range(3) == 0) ? HDR_END + $urandom_range(1, 24) : HDR_END;
      fin = ($urandom_range(9) != 0);
      len = $urandom_range(1, ofs + 64);
      i = $urandom_range(99);
      if (i < 70) begin
        send_bmp(len, fin, s0, s1, w, h, bpp, ofs);
      end else if (i < 90) begin
        case ($urandom_range(5))
          0: if ($urandom_range(1)) s0 = 8'($urandom); else s1 = 8'($urandom);
          1: case ($urandom_range(3))
               0: w = 32'(ICON) + 1;
               1: w = 32'(ICON) - 1;
               2: w = -32'(ICON);
               default: w = $urandom;
             endcase
          2: case ($urandom_range(3))
               0: h = 32'h8000_0000;
               1: h = 32'(ICON) + 1;
               2: h = 32'd0;
               default: h = $urandom;
             endcase
          3: bpp = 16'($urandom);
          4: ofs = $urandom_range(0, HDR_END - 1);
          default: ofs = $urandom;
        endcase
        send_bmp($urandom_range(1, 40), fin, s0, s1, w, h, bpp, ofs);
      end else begin
        len = $urandom_range(1, 30);
        for (int k = 0; k < len; k++) begin
          send_byte(mk_byte((k == 0 && $urandom_range(3) != 0) || $urandom_range(15) == 0,
                            8'($urandom), $urandom_range(29) == 0));
        end
      end
    end
  endtask

  function automatic void check_field(string name, logic [14:0] want, logic [14:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Checks each result transfer and drives the receiver side.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (converted_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %p", $time,
                 res_item);
        mismatches++;
      end else begin
        want_res = converted_q.pop_front();
        check_field("kind", 15'(want_res.kind), 15'(res_item.kind));
        check_field("index", 15'(want_res.index), 15'(res_item.index));
        check_field("value", want_res.value, res_item.value);
        check_field("status", 15'(want_res.status), 15'(res_item.status));
        check_field("done_res", 15'(want_res.done_res), 15'(res_item.done_res));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (res_valid && res_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_bytes();
    test_signature();
    test_full_icon_backpressure();
    test_random_files();
    byte_valid <= 1'b0;
    while (converted_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[bmp_icon_to_tile_converter.f]
hw/rtl/bitc_pkg.sv
hw/rtl/bitc_fifo.sv
hw/rtl/bitc_front.sv
hw/rtl/bitc_back.sv
hw/rtl/bmp_icon_to_tile_converter.sv
test/tb_top.sv
